// File: design/button_encoder_register_expander_defines.svh
// Assertion macros used by the expander design file.
`ifndef BUTTON_ENCODER_REGISTER_EXPANDER_DEFINES_SVH
`define BUTTON_ENCODER_REGISTER_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BERE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BERE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/bere_pkg.sv
`default_nettype none

package bere_pkg;

   // Item kinds on the request channel.
   typedef enum logic [1:0] {
      CMD_BUTTON = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_READ   = 2'd2,
      CMD_WRITE  = 2'd3
   } cmd_type;

   // Register map of the dedicated registers.
   localparam logic [7:0] ADDR_BTN_LO   = 8'd0;
   localparam logic [7:0] ADDR_BTN_HI   = 8'd1;
   localparam logic [7:0] ADDR_ENC_BASE = 8'd2;
   localparam logic [7:0] ADDR_THRESH   = 8'd11;
   localparam logic [7:0] ADDR_TIME     = 8'd12;

   // Number of encoder count registers in the map.
   localparam int ENC_SLOTS = 3;

   // Threshold reset value before scaling down by the filter shift.
   localparam int THRESH_INIT = 1000;

   // Width of the tick prescaler.
   localparam int PRESCALE_W = 5;

   // Register file depth and address width.
   localparam int RF_DEPTH = 256;
   localparam int RF_AW    = 8;

endpackage : bere_pkg

`default_nettype wire

// File: design/button_encoder_register_expander.sv
// Channel  | Handshake            | Beat contents
// ---------+----------------------+----------------------------------------------
// req      | req_valid, req_stall | cmd, button, sample, pins, address, data
// rsp      | rsp_valid, rsp_stall | read_data (one beat per bus read only)
//
// One request beat can be taken every cycle while req_stall is low; all register
// updates happen at the edge that accepts the beat. A bus read answers through
// the registered memory read and then the output register.
// Reset is synchronous and clears the whole register file at once (valid bits).
// req_stall rises only while both the read stage and the output stage hold data
// and rsp_stall is high.
`default_nettype none

`include "button_encoder_register_expander_defines.svh"

module button_encoder_register_expander
   import bere_pkg::*;
#(
   parameter int FILTER_SHIFT   = 3,
   parameter int TICKS_PER_TIME = 20,
   parameter int NUM_ENCODERS   = 3,
   parameter int NUM_BUTTONS    = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [3:0]  req_button_index,
   input  wire logic [13:0] req_analog_sample,
   input  wire logic [5:0]  req_encoder_pins,
   input  wire logic [7:0]  req_reg_address,
   input  wire logic [7:0]  req_write_data,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data
);

   // Scaled threshold width and the common compare width.
   localparam int TSH = FILTER_SHIFT + 2;
   localparam int TW  = 8 + TSH;
   localparam int CW  = (TW > 14) ? TW : 14;
   localparam logic [7:0] THRESH_RESET = 8'(THRESH_INIT >> TSH);

   // Dedicated registers.
   logic [7:0]            btn_lo_ff, btn_lo_in;
   logic [7:0]            btn_hi_ff, btn_hi_in;
   logic [7:0]            enc_ff [ENC_SLOTS];
   logic [7:0]            enc_in [ENC_SLOTS];
   logic [ENC_SLOTS-1:0]  pha_ff, pha_in;
   logic [ENC_SLOTS-1:0]  phb_ff, phb_in;
   logic [7:0]            thresh_ff, thresh_in;
   logic [7:0]            time_ff, time_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;

   // General register memory with a valid bit per entry.
   logic [7:0]            mem_ff [RF_DEPTH];
   logic [RF_DEPTH-1:0]   mem_vld_ff;

   // Read stage and output stage.
   logic                  rd_valid_ff;
   logic                  rd_from_mem_ff;
   logic                  rd_mem_vld_ff;
   logic [7:0]            rd_spec_ff;
   logic [7:0]            mem_rdata_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;

   logic                  req_accept;
   logic                  rd_drain;
   logic                  rd_load;
   logic                  mem_wr;
   logic                  addr_special;
   logic [7:0]            spec_rdata;
   logic [7:0]            rd_data;
   cmd_type               cmd;

   assign cmd = cmd_type'(req_cmd);

   // Handshake control for the two result stages.
   assign rd_drain   = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = rd_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rd_load    = req_accept && (cmd == CMD_READ);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // Address decode and read mux over the dedicated registers.
   always_comb begin
      addr_special = 1'b1;
      spec_rdata   = 8'd0;
      if (req_reg_address == ADDR_BTN_LO) begin
         spec_rdata = btn_lo_ff;
      end else if (req_reg_address == ADDR_BTN_HI) begin
         spec_rdata = btn_hi_ff;
      end else if (req_reg_address == ADDR_THRESH) begin
         spec_rdata = thresh_ff;
      end else if (req_reg_address == ADDR_TIME) begin
         spec_rdata = time_ff;
      end else if (req_reg_address >= ADDR_ENC_BASE &&
                   req_reg_address < ADDR_ENC_BASE + 8'(ENC_SLOTS)) begin
         spec_rdata = 8'd0;
         for (int i = 0; i < ENC_SLOTS; i++) begin
            if (req_reg_address == ADDR_ENC_BASE + 8'(i)) begin
               spec_rdata = enc_ff[i];
            end
         end
      end else begin
         addr_special = 1'b0;
      end
   end

   assign mem_wr = req_accept && (cmd == CMD_WRITE) && !addr_special;

   // Next values of the dedicated registers for the accepted beat.
   always_comb begin
      logic [CW-1:0] thr_scaled;
      logic [7:0]    bit_mask;
      logic          btn_ok;
      logic          pin_a;
      logic          pin_b;
      logic [7:0]    step_a;
      logic [7:0]    step_b;
      logic [PRESCALE_W-1:0] pre_inc;

      btn_lo_in   = btn_lo_ff;
      btn_hi_in   = btn_hi_ff;
      pha_in      = pha_ff;
      phb_in      = phb_ff;
      thresh_in   = thresh_ff;
      time_in     = time_ff;
      prescale_in = prescale_ff;
      for (int i = 0; i < ENC_SLOTS; i++) begin
         enc_in[i] = enc_ff[i];
      end

      thr_scaled = CW'(thresh_ff) << TSH;
      bit_mask   = 8'd1 << req_button_index[2:0];
      btn_ok     = {1'b0, req_button_index} < 5'(NUM_BUTTONS);
      pre_inc    = prescale_ff + 1'b1;
      pin_a      = 1'b0;
      pin_b      = 1'b0;
      step_a     = 8'd0;
      step_b     = 8'd0;

      if (req_accept) begin
         unique case (cmd)
            // Button: a sample above the threshold clears the bit, else sets it.
            CMD_BUTTON: begin
               if (btn_ok) begin
                  if (CW'(req_analog_sample) > thr_scaled) begin
                     if (req_button_index[3]) btn_hi_in = btn_hi_ff & ~bit_mask;
                     else                     btn_lo_in = btn_lo_ff & ~bit_mask;
                  end else begin
                     if (req_button_index[3]) btn_hi_in = btn_hi_ff | bit_mask;
                     else                     btn_lo_in = btn_lo_ff | bit_mask;
                  end
               end
            end
            // Tick: quadrature steps, phase A before phase B, then the timebase.
            CMD_TICK: begin
               for (int i = 0; i < ENC_SLOTS; i++) begin
                  if (i < NUM_ENCODERS) begin
                     pin_a  = req_encoder_pins[2*i];
                     pin_b  = req_encoder_pins[2*i+1];
                     step_a = 8'd0;
                     step_b = 8'd0;
                     if (pin_a != pha_ff[i]) begin
                        step_a = (pin_a == phb_ff[i]) ? 8'd1 : 8'hFF;
                     end
                     if (pin_b != phb_ff[i]) begin
                        step_b = (pin_b != pin_a) ? 8'd1 : 8'hFF;
                     end
                     enc_in[i] = enc_ff[i] + step_a + step_b;
                     pha_in[i] = pin_a;
                     phb_in[i] = pin_b;
                  end
               end
               if (pre_inc == PRESCALE_W'(TICKS_PER_TIME)) begin
                  prescale_in = '0;
                  time_in     = time_ff + 8'd1;
               end else begin
                  prescale_in = pre_inc;
               end
            end
            CMD_READ: begin
            end
            // Bus write to a dedicated register.
            CMD_WRITE: begin
               if (req_reg_address == ADDR_BTN_LO) btn_lo_in = req_write_data;
               if (req_reg_address == ADDR_BTN_HI) btn_hi_in = req_write_data;
               if (req_reg_address == ADDR_THRESH) thresh_in = req_write_data;
               if (req_reg_address == ADDR_TIME)   time_in   = req_write_data;
               for (int i = 0; i < ENC_SLOTS; i++) begin
                  if (req_reg_address == ADDR_ENC_BASE + 8'(i)) begin
                     enc_in[i] = req_write_data;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Dedicated register state.
   always_ff @(posedge clock) begin
      if (reset) begin
         btn_lo_ff   <= 8'd0;
         btn_hi_ff   <= 8'd0;
         pha_ff      <= '0;
         phb_ff      <= '0;
         thresh_ff   <= THRESH_RESET;
         time_ff     <= 8'd0;
         prescale_ff <= '0;
         for (int i = 0; i < ENC_SLOTS; i++) begin
            enc_ff[i] <= 8'd0;
         end
      end else begin
         btn_lo_ff   <= btn_lo_in;
         btn_hi_ff   <= btn_hi_in;
         pha_ff      <= pha_in;
         phb_ff      <= phb_in;
         thresh_ff   <= thresh_in;
         time_ff     <= time_in;
         prescale_ff <= prescale_in;
         for (int i = 0; i < ENC_SLOTS; i++) begin
            enc_ff[i] <= enc_in[i];
         end
      end
   end

   // General register memory: one write port, registered read.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_ff[req_reg_address] <= req_write_data;
      end
      if (rd_load) begin
         mem_rdata_ff <= mem_ff[req_reg_address];
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (mem_wr) begin
         mem_vld_ff[req_reg_address] <= 1'b1;
      end
   end

   // Read stage payload.
   always_ff @(posedge clock) begin
      if (rd_load) begin
         rd_from_mem_ff <= !addr_special;
         rd_mem_vld_ff  <= mem_vld_ff[req_reg_address];
         rd_spec_ff     <= spec_rdata;
      end
   end

   assign rd_data = rd_from_mem_ff ? (rd_mem_vld_ff ? mem_rdata_ff : 8'd0) : rd_spec_ff;

   // Read stage and output stage occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rd_load) begin
            rd_valid_ff <= 1'b1;
         end else if (rd_drain) begin
            rd_valid_ff <= 1'b0;
         end
         if (rd_drain) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output beat payload.
   always_ff @(posedge clock) begin
      if (rd_drain) begin
         rsp_data_ff <= rd_data;
      end
   end

   // The input only stalls while both result stages are full.
   `BERE_ASSERT_IMP(a_stall_needs_full, req_stall, rd_valid_ff && rsp_valid_ff)
   // An accepted bus read always occupies the read stage next cycle.
   `BERE_ASSERT_NXT(a_read_captured, rd_load, rd_valid_ff)
   // The prescaler wraps before it reaches the tick count.
   `BERE_ASSERT_IMP(a_prescale_range, 1'b1, prescale_ff < PRESCALE_W'(TICKS_PER_TIME))

endmodule : button_encoder_register_expander

`default_nettype wire
